>>> design/rcst_pkg.sv
`timescale 1ns / 1ps
package rcst_pkg;

  localparam int OP_W       = 2;
  localparam int ID_W       = 6;
  localparam int STAT_W     = 2;
  localparam int CNT_OUT_W  = 16;
  localparam int SLOT_CNT_W = 7;

  // Allocation can only reach slots below the largest slot count value.
  localparam int REACH      = 2 ** SLOT_CNT_W;
  localparam int FIND_W     = SLOT_CNT_W;

  // Free-slot search: group size of the first encoder level.
  localparam int GRP        = 16;
  localparam int GRP_W      = 4;

  localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_ID      = 2'd1,
    ST_FULL        = 2'd2,
    ST_CREATE_FAIL = 2'd3
  } status_t;

  typedef struct packed {
    logic load;    // capture the input beat and read the count memory
    logic commit;  // update the table and load the result register
  } ctrl_cmd_t;

endpackage

>>> design/rcst_ctrl.sv
`timescale 1ns / 1ps
module rcst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rcst_pkg::ctrl_cmd_t cmd
);
  import rcst_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = in_valid && (state_r == S_IDLE);
  assign cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold in EXEC while the previous result is still stalled
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit while result register is occupied");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted beat did not move to execute");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");
`endif

endmodule

>>> design/rcst_dp.sv
`timescale 1ns / 1ps
module rcst_dp #(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rcst_pkg::ctrl_cmd_t               cmd,
  input  logic [rcst_pkg::SLOT_CNT_W-1:0]   slot_count,
  input  logic [rcst_pkg::OP_W-1:0]         in_op,
  input  logic [rcst_pkg::ID_W-1:0]         in_slot_id,
  input  logic                              in_auto_free,
  input  logic                              in_create_ok,
  output logic [rcst_pkg::STAT_W-1:0]       out_status,
  output logic [rcst_pkg::ID_W-1:0]         out_handle,
  output logic [rcst_pkg::CNT_OUT_W-1:0]    out_count_after,
  output logic                              out_slot_freed
);
  import rcst_pkg::*;

  // Only slots below REACH can ever be allocated or addressed.
  localparam int USED = (SLOTS < REACH) ? SLOTS : REACH;
  localparam int AW   = (USED > 1) ? $clog2(USED) : 1;
  localparam int NG   = (USED + GRP - 1) / GRP;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // item capture
  op_t             op_r;
  logic [ID_W-1:0] id_r;
  logic            af_r;
  logic            ok_r;

  // count memory: {auto_free, count}; content of a free slot is don't care
  logic [COUNT_BITS:0] mem [USED];
  logic [COUNT_BITS:0] rd_word_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [COUNT_BITS:0] mem_wd;

  logic [USED-1:0] in_use_r;
  logic            use_we;
  logic [AW-1:0]   use_wa;
  logic            use_wd;

  // free-slot search
  logic [NG*GRP-1:0] free_vec;
  logic [NG-1:0]     grp_hit_nxt, grp_hit_r;
  logic [GRP_W-1:0]  grp_pos_nxt [NG];
  logic [GRP_W-1:0]  grp_pos_r   [NG];
  logic              found;
  logic [FIND_W-1:0] sel_idx;

  logic                  id_in_range;
  logic                  id_used;
  logic [COUNT_BITS-1:0] cnt;
  logic                  af_old;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_dec;

  status_t              status_nxt;
  logic [ID_W-1:0]      handle_nxt;
  logic [CNT_OUT_W-1:0] count_nxt;
  logic                 freed_nxt;

  status_t              status_r;
  logic [ID_W-1:0]      handle_r;
  logic [CNT_OUT_W-1:0] count_r;
  logic                 freed_r;

  for (genvar i = 0; i < NG * GRP; i++) begin : g_free
    if (i < USED) begin : g_slot
      assign free_vec[i] = !in_use_r[i] && (FIND_W'(i) < slot_count);
    end else begin : g_pad
      assign free_vec[i] = 1'b0;
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_nxt[g] = |free_vec[g*GRP +: GRP];
      grp_pos_nxt[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (free_vec[g*GRP + b]) grp_pos_nxt[g] = GRP_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit_r <= grp_hit_nxt;
    grp_pos_r <= grp_pos_nxt;
  end

  always_comb begin
    found   = 1'b0;
    sel_idx = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        found   = 1'b1;
        sel_idx = FIND_W'(g * GRP + int'(grp_pos_r[g]));
      end
    end
  end

  always_comb begin
    id_in_range = (int'(id_r) < USED);
    id_used     = id_in_range && in_use_r[AW'(id_r)];
    cnt         = rd_word_r[COUNT_BITS-1:0];
    af_old      = rd_word_r[COUNT_BITS];
    cnt_inc     = (cnt == CMAX) ? cnt : cnt + 1'b1;
    cnt_dec     = (cnt == '0) ? cnt : cnt - 1'b1;

    status_nxt = ST_BAD_ID;
    handle_nxt = id_r;
    count_nxt  = '0;
    freed_nxt  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = AW'(id_r);
    mem_wd     = '0;
    use_we     = 1'b0;
    use_wa     = AW'(id_r);
    use_wd     = 1'b0;

    case (op_r)
      OP_ALLOC: begin
        mem_wa = AW'(sel_idx);
        use_wa = AW'(sel_idx);
        if (!found) begin
          status_nxt = ST_FULL;
          handle_nxt = '0;
        end else if (!ok_r) begin
          // slot was free and stays free
          status_nxt = ST_CREATE_FAIL;
          handle_nxt = ID_W'(sel_idx);
        end else begin
          status_nxt = ST_OK;
          handle_nxt = ID_W'(sel_idx);
          count_nxt  = CNT_OUT_W'(COUNT_BITS'(1));
          mem_we     = 1'b1;
          mem_wd     = {af_r, COUNT_BITS'(1)};
          use_we     = 1'b1;
          use_wd     = 1'b1;
        end
      end
      OP_ACQUIRE: begin
        if (id_used) begin
          status_nxt = ST_OK;
          count_nxt  = CNT_OUT_W'(cnt_inc);
          mem_we     = 1'b1;
          mem_wd     = {af_old, cnt_inc};
        end
      end
      OP_RELEASE: begin
        if (id_used) begin
          status_nxt = ST_OK;
          if ((cnt_dec == '0) && af_old) begin
            freed_nxt = 1'b1;
            use_we    = 1'b1;
          end else begin
            count_nxt = CNT_OUT_W'(cnt_dec);
            mem_we    = 1'b1;
            mem_wd    = {af_old, cnt_dec};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_op);
      id_r      <= in_slot_id;
      af_r      <= in_auto_free;
      ok_r      <= in_create_ok;
      rd_word_r <= mem[AW'(in_slot_id)];
    end
    if (cmd.commit && mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      handle_r <= handle_nxt;
      count_r  <= count_nxt;
      freed_r  <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (cmd.commit && use_we) begin
      in_use_r[use_wa] <= use_wd;
    end
  end

  assign out_status      = status_r;
  assign out_handle      = handle_r;
  assign out_count_after = count_r;
  assign out_slot_freed  = freed_r;

`ifndef NO_ASSERTIONS
  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == OP_ALLOC) && found)
      |-> (!in_use_r[AW'(sel_idx)] && (sel_idx < slot_count)))
    else $error("allocation picked a used or closed slot");

  a_alloc_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == OP_ALLOC) && found && ok_r)
      |=> in_use_r[$past(mem_wa)])
    else $error("allocated slot not marked in use");
`endif

endmodule

>>> design/refcounted_slot_table.sv
`timescale 1ns / 1ps
// Reference-counted slot table.
// Input channel (in_valid/in_ready): one beat is one operation, allocate,
// acquire by id or release by id. Result channel (out_valid/out_ready): one
// beat per operation with status, handle, count after and a freed flag.
// cfg_wr_en/cfg_wr_data write the slot count that bounds allocation; write
// it only while no operation is in flight.
// The edge that takes the input beat reads the count memory and enters the
// execute cycle, which does the read-modify-write and loads the result
// register once the receiver has room; no new input beat is taken until execute ends.
// The free-slot search is a registered two-level priority encoder, its first
// level registered on the accept edge and its second resolved in execute.
// A result waiting on a stalled receiver does not block the next input
// beat; that beat then holds in execute until the result register drains.
// Reset clears every in-use bit and sets the slot count to 64; there is no
// clearing pass, as the count memory contents matter only for used slots.
module refcounted_slot_table #(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rcst_pkg::OP_W-1:0]         in_op,
  input  logic [rcst_pkg::ID_W-1:0]         in_slot_id,
  input  logic                              in_auto_free,
  input  logic                              in_create_ok,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcst_pkg::STAT_W-1:0]       out_status,
  output logic [rcst_pkg::ID_W-1:0]         out_handle,
  output logic [rcst_pkg::CNT_OUT_W-1:0]    out_count_after,
  output logic                              out_slot_freed,
  input  logic                              cfg_wr_en,
  input  logic [rcst_pkg::SLOT_CNT_W-1:0]   cfg_wr_data
);
  import rcst_pkg::*;

  ctrl_cmd_t             cmd;
  logic [SLOT_CNT_W-1:0] slot_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RST;
    end else if (cfg_wr_en) begin
      slot_count_r <= cfg_wr_data;
    end
  end

  rcst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rcst_dp #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .slot_count      (slot_count_r),
    .in_op           (in_op),
    .in_slot_id      (in_slot_id),
    .in_auto_free    (in_auto_free),
    .in_create_ok    (in_create_ok),
    .out_status      (out_status),
    .out_handle      (out_handle),
    .out_count_after (out_count_after),
    .out_slot_freed  (out_slot_freed)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
import rcst_pkg::*;

localparam int          TABLE_SLOTS = 64;
localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

typedef struct packed {
  op_t             op;
  logic [ID_W-1:0] slot_id;
  logic            auto_free;
  logic            create_ok;
} op_item_t;

typedef struct packed {
  logic [STAT_W-1:0]    status;
  logic [ID_W-1:0]      handle;
  logic [CNT_OUT_W-1:0] count_after;
  logic                 slot_freed;
} result_t;

class slot_table_scoreboard;
  bit              in_use    [TABLE_SLOTS];
  logic [15:0]     ref_cnt   [TABLE_SLOTS];
  bit              auto_free [TABLE_SLOTS];
  logic [6:0]      slot_count;
  result_t         predicted_results [$];
  int              failures;

  function new();
    slot_count  = SLOT_COUNT_RST;
    failures    = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      clear_slot(i);
    end
  endfunction

  function void clear_slot(int i);
    in_use[i]    = 1'b0;
    ref_cnt[i]   = '0;
    auto_free[i] = 1'b0;
  endfunction

  // Advance the table by one accepted input beat and queue the result it owes.
  function void note_op(op_item_t it);
    result_t r;
    int      lim;
    int      pick;
    r.status      = ST_BAD_ID;
    r.handle      = it.slot_id;
    r.count_after = '0;
    r.slot_freed  = 1'b0;
    if (it.op == OP_ALLOC) begin
      lim  = (slot_count < TABLE_SLOTS) ? int'(slot_count) : TABLE_SLOTS;
      pick = -1;
      for (int i = lim - 1; i >= 0; i--) begin
        if (!in_use[i]) pick = i;
      end
      r.handle = '0;
      if (pick < 0) begin
        r.status = ST_FULL;
      end else if (!it.create_ok) begin
        clear_slot(pick);
        r.status = ST_CREATE_FAIL;
        r.handle = 6'(pick);
      end else begin
        in_use[pick]    = 1'b1;
        ref_cnt[pick]   = 16'd1;
        auto_free[pick] = it.auto_free;
        r.status        = ST_OK;
        r.handle        = 6'(pick);
        r.count_after   = 16'd1;
      end
    end else if (it.op != OP_RSVD && in_use[it.slot_id]) begin
      r.status = ST_OK;
      if (it.op == OP_ACQUIRE) begin
        if (ref_cnt[it.slot_id] != COUNT_MAX) ref_cnt[it.slot_id]++;
      end else begin
        if (ref_cnt[it.slot_id] != 0) ref_cnt[it.slot_id]--;
        if (ref_cnt[it.slot_id] == 0 && auto_free[it.slot_id]) begin
          clear_slot(it.slot_id);
          r.slot_freed = 1'b1;
        end
      end
      r.count_after = ref_cnt[it.slot_id];
    end
    predicted_results.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (predicted_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result beat: status=%0d handle=%0d count=%0d freed=%0d",
                 got.status, got.handle, got.count_after, got.slot_freed);
      return;
    end
    want = predicted_results.pop_front();
    if (got.status !== want.status || got.handle !== want.handle ||
        got.count_after !== want.count_after || got.slot_freed !== want.slot_freed) begin
      failures++;
      if (failures <= 10)
        $display("mismatch: expected status=%0d handle=%0d count=%0d freed=%0d, %s",
                 want.status, want.handle, want.count_after, want.slot_freed,
                 $sformatf("got status=%0d handle=%0d count=%0d freed=%0d",
                           got.status, got.handle, got.count_after, got.slot_freed));
    end
  endfunction
endclass

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 150;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op       = '0;
  logic [ID_W-1:0]       in_slot_id  = '0;
  logic                  in_auto_free = 1'b0;
  logic                  in_create_ok = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [STAT_W-1:0]     out_status;
  logic [ID_W-1:0]       out_handle;
  logic [CNT_OUT_W-1:0]  out_count_after;
  logic                  out_slot_freed;
  logic                  cfg_wr_en   = 1'b0;
  logic [SLOT_CNT_W-1:0] cfg_wr_data = '0;

  slot_table_scoreboard sb;
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  bit holdoff_req = 1'b0;
  int stall_cycles = 0;

  refcounted_slot_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_slot_id      (in_slot_id),
    .in_auto_free    (in_auto_free),
    .in_create_ok    (in_create_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_handle      (out_handle),
    .out_count_after (out_count_after),
    .out_slot_freed  (out_slot_freed),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic op_item_t op_beat(op_t op, logic [ID_W-1:0] id, logic af, logic ok);
    op_item_t it;
    it.op        = op;
    it.slot_id   = id;
    it.auto_free = af;
    it.create_ok = ok;
    return it;
  endfunction

  // Mostly target live handles so acquire/release reach real counts.
  function automatic op_item_t draw_op(int alloc_pct);
    op_item_t it;
    int       r;
    int       live [$];
    it.slot_id   = 6'($urandom_range(0, 63));
    it.auto_free = 1'($urandom_range(0, 1));
    it.create_ok = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 99);
    if (r < alloc_pct) it.op = OP_ALLOC;
    else if (r < 97) it.op = $urandom_range(0, 1) ? OP_ACQUIRE : OP_RELEASE;
    else it.op = OP_RSVD;
    if (it.op != OP_ALLOC && $urandom_range(0, 9) < 8) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (sb.in_use[i]) live.push_back(i);
      end
      if (live.size() > 0) it.slot_id = 6'(live[$urandom_range(0, live.size() - 1)]);
    end
    return it;
  endfunction

  task automatic send_op(op_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= it.op;
    in_slot_id   <= it.slot_id;
    in_auto_free <= it.auto_free;
    in_create_ok <= it.create_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_op(it);
  endtask

  // Hold the input until every owed result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slot_count(logic [SLOT_CNT_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.slot_count = v;
  endtask

  task automatic receive_results();
    int      gap;
    int      n;
    result_t got;
    n = 0;
    forever begin
      if (n % 50 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 17);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        gap = HOLDOFF_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status      = out_status;
      got.handle      = out_handle;
      got.count_after = out_count_after;
      got.slot_freed  = out_slot_freed;
      sb.check_result(got);
      n++;
    end
  endtask

  task automatic run_directed();
    set_slot_count(7'd0);
    send_op(op_beat(OP_ALLOC, 6'd63, 1'b1, 1'b1));
    set_slot_count(7'd2);
    send_op(op_beat(OP_ALLOC, 6'd63, 1'b1, 1'b1));
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b1, 1'b0));
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b0, 1'b1));
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b0, 1'b1));
    send_op(op_beat(OP_ACQUIRE, 6'd0, 1'b0, 1'b0));
    send_op(op_beat(OP_ACQUIRE, 6'd5, 1'b1, 1'b1));
    send_op(op_beat(OP_RELEASE, 6'd63, 1'b1, 1'b1));
    send_op(op_beat(OP_RSVD, 6'd0, 1'b0, 1'b1));
    send_op(op_beat(OP_RSVD, 6'd63, 1'b1, 1'b0));
    send_op(op_beat(OP_RELEASE, 6'd0, 1'b0, 1'b0));
    send_op(op_beat(OP_RELEASE, 6'd0, 1'b0, 1'b0));
    send_op(op_beat(OP_RELEASE, 6'd0, 1'b0, 1'b0));
    // release without auto-free parks the slot at zero, then stays there
    send_op(op_beat(OP_RELEASE, 6'd1, 1'b1, 1'b1));
    send_op(op_beat(OP_RELEASE, 6'd1, 1'b1, 1'b1));
    send_op(op_beat(OP_ACQUIRE, 6'd1, 1'b0, 1'b1));
    // slot 1 sits above the lowered count but stays reachable by id
    set_slot_count(7'd1);
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b1, 1'b1));
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b1, 1'b1));
    send_op(op_beat(OP_RELEASE, 6'd1, 1'b0, 1'b0));
    send_op(op_beat(OP_ACQUIRE, 6'd1, 1'b0, 1'b0));
    set_slot_count(7'd127);
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b1, 1'b0));
    send_op(op_beat(OP_ALLOC, 6'd0, 1'b0, 1'b1));
  endtask

  task automatic run_phase(logic [SLOT_CNT_W-1:0] count_val, int n_items, int alloc_pct,
                           bit with_holdoff);
    set_slot_count(count_val);
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      if (with_holdoff && k == 30) begin
        holdoff_req = 1'b1;
        tx_calm     = 1'b1;
      end
      if ($urandom_range(0, 59) == 0) drain();
      send_op(draw_op(alloc_pct));
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    fork
      receive_results();
    join_none
    run_directed();
    run_phase(7'd64, 145, 60, 1'b1);
    run_phase(7'd5, 145, 45, 1'b0);
    run_phase(7'd127, 145, 35, 1'b0);
    run_phase(7'd1, 145, 40, 1'b0);
    run_phase(7'd0, 120, 30, 1'b0);
    run_phase(7'($urandom_range(2, 63)), 145, 50, 1'b1);
    run_phase(7'd64, 145, 55, 1'b0);
    run_phase(7'd17, 145, 40, 1'b0);
    drain();
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rcst_pkg.sv
design/rcst_ctrl.sv
design/rcst_dp.sv
design/refcounted_slot_table.sv
dv/testbench.sv
